// ===== rtl/graph_reachability_dfs_core_assert.svh =====
// Assertion macros used by the reachability engine checker.
`ifndef GRAPH_REACHABILITY_DFS_CORE_ASSERT_SVH
`define GRAPH_REACHABILITY_DFS_CORE_ASSERT_SVH

// Generic clocked assertion with asynchronous active-low reset disable.
`define GRDFS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("grdfs assertion failed");

// A stalled word keeps the given signal unchanged in the next cycle.
`define GRDFS_ASSERT_HOLD(name, clk, rst_n, vld, rdy, sig) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (vld && !rdy) |=> $stable(sig)) \
    else $error("grdfs stalled word changed");

`endif

// ===== rtl/grdfs_pkg.sv =====
// Package with widths, types and operation codes of the reachability engine.
package grdfs_pkg;

  localparam int unsigned VertexW        = 6;
  localparam int unsigned RowW           = 64;
  localparam int unsigned CountW         = 7;
  localparam int unsigned MaxVerticesDef = 64;
  localparam logic [CountW-1:0] VertexCountReset = 7'd64;

  typedef logic [VertexW-1:0] vertex_t;
  typedef logic [RowW-1:0]    row_t;
  typedef logic [CountW-1:0]  count_t;

  typedef enum logic [1:0] {
    OpWriteRow = 2'd0,
    OpSearch   = 2'd1,
    OpClear    = 2'd2
  } op_e;

  typedef struct packed {
    logic    we;
    logic    re;
    vertex_t addr;
    row_t    wdata;
  } adj_req_t;

  typedef struct packed {
    logic    we;
    logic    re;
    vertex_t addr;
    vertex_t wdata;
  } stk_req_t;

endpackage

// ===== rtl/grdfs_in_if.sv =====
// Input channel carrying one command word.
interface grdfs_in_if;
  import grdfs_pkg::*;

  logic    valid;
  logic    ready;
  logic [1:0] op;
  vertex_t vertex;
  row_t    row_bits;

  modport source (output valid, output op, output vertex, output row_bits, input ready);
  modport sink   (input valid, input op, input vertex, input row_bits, output ready);
endinterface

// ===== rtl/grdfs_out_if.sv =====
// Output channel carrying one search result word.
interface grdfs_out_if;
  import grdfs_pkg::*;

  logic   valid;
  logic   ready;
  row_t   visited_mask;
  count_t visited_count;

  modport source (output valid, output visited_mask, output visited_count, input ready);
  modport sink   (input valid, input visited_mask, input visited_count, output ready);
endinterface

// ===== rtl/grdfs_cfg_if.sv =====
// Configuration write channel for the vertex count register.
interface grdfs_cfg_if;
  import grdfs_pkg::*;

  logic   valid;
  logic   ready;
  count_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/grdfs_adj_mem.sv =====
// Adjacency row memory with per-row valid bits so unwritten rows read as zero.
module grdfs_adj_mem #(
  parameter int unsigned MAX_VERTICES = grdfs_pkg::MaxVerticesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  grdfs_pkg::adj_req_t req_i,
  output grdfs_pkg::row_t    row_o
);
  import grdfs_pkg::*;

  localparam int unsigned AddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  row_t                    mem_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] valid_q;
  row_t                    rdata_q;
  logic                    rvalid_q;
  logic [AddrW-1:0]        addr;

  assign addr = req_i.addr[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[addr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= valid_q[addr];
      end
    end
  end

  assign row_o = rvalid_q ? rdata_q : '0;
endmodule

// ===== rtl/grdfs_stack.sv =====
// Vertex stack memory with one shared port and registered read data.
module grdfs_stack #(
  parameter int unsigned MAX_VERTICES = grdfs_pkg::MaxVerticesDef
) (
  input  logic                clk_i,
  input  grdfs_pkg::stk_req_t req_i,
  output grdfs_pkg::vertex_t  rdata_o
);
  import grdfs_pkg::*;

  localparam int unsigned AddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  vertex_t          mem_q [MAX_VERTICES];
  vertex_t          rdata_q;
  logic [AddrW-1:0] addr;

  assign addr = req_i.addr[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[addr];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/graph_reachability_dfs_core.sv =====
// Top level of the depth-first reachability engine over an adjacency bit matrix.
// The input channel takes command words: write row loads the successor mask of
// one vertex, search marks every vertex reachable from a start vertex, and clear
// drops all marks. Only a search produces an output word, carrying the visited
// mask and its population count; marks accumulate across searches.
// The configuration channel writes the vertex count and is always ready.
// Write row and clear complete in the idle state. A search walks an explicit stack held in
// memory: each popped vertex passes through four steps (stack read, row read, row check
// and the push step that finds no successor left) and each newly marked vertex
// one more push step. A search that marks nothing goes straight to the result
// state. The next command word is taken only after the result word is registered.
// The search steps follow from the single port of the stack memory and the registered
// read data of both memories. The result is held in an output register; a
// stalled receiver holds the engine only when the next result is ready.
// Reset clears the marks, the stack pointer and all adjacency rows (through
// per-row valid bits, with no clearing pass) and sets the vertex count to 64.
module graph_reachability_dfs_core #(
  parameter int unsigned MAX_VERTICES = grdfs_pkg::MaxVerticesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  grdfs_in_if.sink   in_if,
  grdfs_out_if.source out_if,
  grdfs_cfg_if.sink  cfg_if
);
  import grdfs_pkg::*;

  localparam int unsigned AddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam count_t      MaxV  = count_t'(MAX_VERTICES);

  typedef enum logic [2:0] {
    StIdle, StPop, StFetch, StRow, StPush, StResult
  } state_e;

  state_e           state_q, state_d;
  count_t           vcount_q, vcount_d;
  row_t             visited_q, visited_d;
  count_t           count_q, count_d;
  logic [AddrW:0]   sp_q, sp_d;
  row_t             fresh_q, fresh_d;
  logic             out_valid_q, out_valid_d;
  row_t             out_mask_q, out_mask_d;
  count_t           out_count_q, out_count_d;

  count_t           n_eff;
  row_t             in_use;
  logic [AddrW-1:0] pick;
  row_t             pick_bit;
  logic [AddrW:0]   sp_dec;
  adj_req_t         adj_req;
  stk_req_t         stk_req;
  row_t             adj_row;
  vertex_t          stk_rdata;

  grdfs_adj_mem #(.MAX_VERTICES(MAX_VERTICES)) u_adj (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (adj_req),
    .row_o (adj_row)
  );

  grdfs_stack #(.MAX_VERTICES(MAX_VERTICES)) u_stack (
    .clk_i  (clk_i),
    .req_i  (stk_req),
    .rdata_o(stk_rdata)
  );

  assign n_eff = (vcount_q > MaxV) ? MaxV : vcount_q;

  always_comb begin
    for (int i = 0; i < RowW; i++) begin
      in_use[i] = (count_t'(i) < n_eff);
    end
  end

  always_comb begin
    pick = '0;
    for (int i = RowW - 1; i >= 0; i--) begin
      if (fresh_q[i]) begin
        pick = AddrW'(i);
      end
    end
  end

  assign pick_bit = row_t'(1) << pick;
  assign sp_dec   = sp_q - 1'b1;

  assign in_if.ready      = (state_q == StIdle);
  assign cfg_if.ready     = 1'b1;
  assign out_if.valid         = out_valid_q;
  assign out_if.visited_mask  = out_mask_q;
  assign out_if.visited_count = out_count_q;

  always_comb begin
    state_d     = state_q;
    vcount_d    = vcount_q;
    visited_d   = visited_q;
    count_d     = count_q;
    sp_d        = sp_q;
    fresh_d     = fresh_q;
    out_valid_d = out_valid_q;
    out_mask_d  = out_mask_q;
    out_count_d = out_count_q;
    adj_req     = '0;
    stk_req     = '0;

    if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
    if (cfg_if.valid) begin
      vcount_d = cfg_if.data;
    end

    unique case (state_q)
      StIdle: begin
        if (in_if.valid) begin
          unique case (in_if.op)
            OpWriteRow: begin
              if ({1'b0, in_if.vertex} < MaxV) begin
                adj_req.we    = 1'b1;
                adj_req.addr  = in_if.vertex;
                adj_req.wdata = in_if.row_bits;
              end
            end
            OpSearch: begin
              if ({1'b0, in_if.vertex} < n_eff && !visited_q[in_if.vertex]) begin
                visited_d[in_if.vertex] = 1'b1;
                count_d       = count_q + 1'b1;
                stk_req.we    = 1'b1;
                stk_req.addr  = '0;
                stk_req.wdata = in_if.vertex;
                sp_d          = (AddrW + 1)'(1);
                state_d       = StPop;
              end else begin
                state_d = StResult;
              end
            end
            OpClear: begin
              visited_d = '0;
              count_d   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      StPop: begin
        if (sp_q == '0) begin
          state_d = StResult;
        end else begin
          stk_req.re   = 1'b1;
          stk_req.addr = vertex_t'(sp_dec[AddrW-1:0]);
          sp_d         = sp_dec;
          state_d      = StFetch;
        end
      end
      StFetch: begin
        adj_req.re   = 1'b1;
        adj_req.addr = stk_rdata;
        state_d      = StRow;
      end
      StRow: begin
        fresh_d = adj_row & in_use & ~visited_q;
        state_d = StPush;
      end
      StPush: begin
        if (fresh_q == '0) begin
          state_d = StPop;
        end else begin
          visited_d     = visited_q | pick_bit;
          count_d       = count_q + 1'b1;
          fresh_d       = fresh_q & ~pick_bit;
          stk_req.we    = 1'b1;
          stk_req.addr  = vertex_t'(sp_q[AddrW-1:0]);
          stk_req.wdata = vertex_t'(pick);
          sp_d          = sp_q + 1'b1;
        end
      end
      StResult: begin
        if (!out_valid_q || out_if.ready) begin
          out_valid_d = 1'b1;
          out_mask_d  = visited_q;
          out_count_d = count_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      vcount_q    <= VertexCountReset;
      visited_q   <= '0;
      count_q     <= '0;
      sp_q        <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
      out_mask_q  <= '0;
      out_count_q <= '0;
    end else begin
      state_q     <= state_d;
      vcount_q    <= vcount_d;
      visited_q   <= visited_d;
      count_q     <= count_d;
      sp_q        <= sp_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
      out_mask_q  <= out_mask_d;
      out_count_q <= out_count_d;
    end
  end
endmodule

// ===== rtl/grdfs_checker.sv =====
// Port-level checker for the reachability engine, bound to the top level.
`include "graph_reachability_dfs_core_assert.svh"

module grdfs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [1:0]        in_op_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input grdfs_pkg::row_t   out_mask_i,
  input grdfs_pkg::count_t out_count_i
);
  import grdfs_pkg::*;

  `GRDFS_ASSERT(a_out_valid_holds, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i)
  `GRDFS_ASSERT_HOLD(a_out_mask_holds, clk_i, rst_ni, out_valid_i, out_ready_i, out_mask_i)
  `GRDFS_ASSERT(a_count_matches_mask, clk_i, rst_ni, out_valid_i |-> (out_count_i == count_t'($countones(out_mask_i))))
  `GRDFS_ASSERT(a_search_busy, clk_i, rst_ni, (in_valid_i && in_ready_i && in_op_i == OpSearch) |=> !in_ready_i)
endmodule

bind graph_reachability_dfs_core grdfs_checker u_grdfs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_if.valid),
  .in_ready_i (in_if.ready),
  .in_op_i    (in_if.op),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .out_mask_i (out_if.visited_mask),
  .out_count_i(out_if.visited_count)
);

// ===== bench/tb_graph_reachability_dfs_core.sv =====
// Self-checking testbench of the reachability engine: directed and random command words against a predictor.
module tb_graph_reachability_dfs_core;
  import grdfs_pkg::*;

  localparam int unsigned MaxV         = MaxVerticesDef;
  localparam int unsigned SettleCycles = 4 * MaxV + 16;
  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned PhaseCount   = 10;
  localparam int unsigned PhaseWords   = 93;
  localparam logic [1:0]  OpUnused     = 2'd3;

  typedef struct {
    row_t   mask;
    count_t count;
  } reach_result_t;

  class reach_scoreboard;
    row_t          adj_rows [MaxV];
    row_t          marks;
    count_t        vcount;
    reach_result_t expected_q [$];
    int unsigned   errors;
    int unsigned   checked;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      marks   = '0;
      vcount  = VertexCountReset;
      errors  = 0;
      checked = 0;
    endfunction

    function int unsigned active_count();
      return (vcount > MaxV) ? MaxV : int'(vcount);
    endfunction

    function void set_vertex_count(count_t value);
      vcount = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void mark_reachable(vertex_t start);
      int unsigned n;
      row_t        in_use;
      row_t        fresh;
      int unsigned walk_q [$];
      int unsigned v;
      n      = active_count();
      in_use = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      if (start >= n || marks[start]) return;
      marks[start] = 1'b1;
      walk_q.push_back(start);
      while (walk_q.size() > 0) begin
        v     = walk_q.pop_back();
        fresh = adj_rows[v] & in_use & ~marks;
        for (int j = 0; j < 64; j++) begin
          if (fresh[j]) begin
            marks[j] = 1'b1;
            walk_q.push_back(j);
          end
        end
      end
    endfunction

    function void note_word(logic [1:0] op, vertex_t v, row_t r);
      reach_result_t res;
      case (op)
        OpWriteRow: begin
          if (v < MaxV) adj_rows[v] = r;
        end
        OpSearch: begin
          mark_reachable(v);
          res.mask  = marks;
          res.count = count_t'($countones(marks));
          expected_q.push_back(res);
        end
        OpClear: begin
          marks = '0;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(row_t mask, count_t count);
      reach_result_t res;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: visited_mask %h visited_count %0d",
               mask, count);
        errors++;
        return;
      end
      res = expected_q.pop_front();
      checked++;
      if (mask !== res.mask) begin
        $error("visited_mask expected %h actual %h", res.mask, mask);
        errors++;
      end
      if (count !== res.count) begin
        $error("visited_count expected %0d actual %0d", res.count, count);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  grdfs_in_if  in_ch ();
  grdfs_out_if out_ch ();
  grdfs_cfg_if cfg_ch ();

  graph_reachability_dfs_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  reach_scoreboard sb = new();

  int unsigned burst_left   = 0;
  bit          sending      = 1'b0;
  int unsigned words_sent   = 0;
  int unsigned settings_cnt = 0;
  int unsigned stall_left   = 0;
  int unsigned stall_mode   = 0;
  int unsigned idle_cycles  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.visited_mask, out_ch.visited_count);
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(1, 40);
    end
    stall_left--;
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= 1'($urandom_range(0, 1));
      default: out_ch.ready <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no word moved for %0d cycles", IdleLimit);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input vertex_t v, input row_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.vertex   <= v;
    in_ch.row_bits <= r;
    sending = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_word(op, v, r);
    words_sent++;
    burst_left--;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      sending = 1'b0;
    end
  endtask

  task automatic drain_results();
    if (sending) begin
      in_ch.valid <= 1'b0;
      sending = 1'b0;
    end
    burst_left = 0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(input count_t value);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_vertex_count(value);
    settings_cnt++;
  endtask

  function automatic row_t rand_row();
    return {$urandom(), $urandom()};
  endfunction

  function automatic vertex_t pick_vertex(int unsigned span);
    if (span == 0 || $urandom_range(0, 9) == 0) return vertex_t'($urandom_range(0, 63));
    return vertex_t'($urandom_range(0, span - 1));
  endfunction

  function automatic row_t make_row(int unsigned span, vertex_t v);
    row_t in_use;
    in_use = (span >= 64) ? '1 : ((64'd1 << span) - 64'd1);
    case ($urandom_range(0, 7))
      0:       return rand_row();
      1:       return rand_row() & rand_row() & rand_row();
      2:       return rand_row() & rand_row() & in_use;
      3:       return row_t'(1) << pick_vertex(span);
      4:       return '0;
      5:       return '1;
      6:       return (row_t'(1) << 6'(v + 1)) | (rand_row() & rand_row() & rand_row() & in_use);
      default: return rand_row() & in_use;
    endcase
  endfunction

  task automatic run_random_phase(input int unsigned n_words);
    int unsigned start_cnt;
    int unsigned span;
    int unsigned loads;
    vertex_t     v;
    start_cnt = words_sent;
    span      = sb.active_count();
    while (words_sent - start_cnt < n_words) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 2) == 0) send_word(OpClear, vertex_t'($urandom()), rand_row());
        loads = $urandom_range(1, (span < 10) ? span + 2 : 12);
        repeat (loads) begin
          v = pick_vertex(span);
          send_word(OpWriteRow, v, make_row(span, v));
        end
        repeat ($urandom_range(1, 3)) send_word(OpSearch, pick_vertex(span), rand_row());
      end else begin
        case ($urandom_range(0, 3))
          0: send_word(OpUnused, vertex_t'($urandom()), rand_row());
          1: send_word(OpSearch, vertex_t'($urandom()), rand_row());
          2: send_word(OpWriteRow, vertex_t'($urandom()), rand_row());
          default: send_word(OpClear, vertex_t'($urandom()), rand_row());
        endcase
      end
    end
  endtask

  initial begin
    count_t phase_counts [5];
    count_t vc;
    phase_counts    = '{7'd1, 7'd64, 7'd2, 7'd127, 7'd0};
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = OpWriteRow;
    in_ch.vertex    = '0;
    in_ch.row_bits  = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    out_ch.ready    = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(OpSearch, 6'd0, '0);
    send_word(OpSearch, 6'd63, '0);
    send_word(OpUnused, 6'd63, '1);
    send_word(OpClear, 6'd0, '0);
    send_word(OpWriteRow, 6'd0, '1);
    send_word(OpWriteRow, 6'd63, 64'd1);
    send_word(OpSearch, 6'd63, '0);
    send_word(OpSearch, 6'd5, '0);
    send_word(OpClear, 6'd63, '1);
    send_word(OpWriteRow, 6'd0, '0);
    send_word(OpWriteRow, 6'd1, (64'd1 << 2) | (64'd1 << 63));
    send_word(OpWriteRow, 6'd2, (64'd1 << 1) | (64'd1 << 3));
    send_word(OpSearch, 6'd1, '0);
    write_vertex_count(7'd4);
    send_word(OpSearch, 6'd0, '0);
    send_word(OpClear, 6'd0, '0);
    send_word(OpSearch, 6'd1, '0);
    send_word(OpSearch, 6'd10, '0);
    write_vertex_count(7'd0);
    send_word(OpSearch, 6'd0, '0);
    send_word(OpWriteRow, 6'd63, '1);
    write_vertex_count(7'd127);
    send_word(OpSearch, 6'd63, '0);
    send_word(OpClear, 6'd0, '0);

    for (int p = 0; p < PhaseCount; p++) begin
      if (p < 5) begin
        vc = phase_counts[p];
      end else if ($urandom_range(0, 3) == 0) begin
        vc = count_t'($urandom_range(0, 127));
      end else begin
        vc = count_t'($urandom_range(3, 64));
      end
      write_vertex_count(vc);
      run_random_phase(PhaseWords);
    end

    drain_results();
    $display("covered %0d command words and %0d vertex count settings, %0d results checked",
             words_sent, settings_cnt, sb.checked);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/grdfs_pkg.sv
rtl/grdfs_in_if.sv
rtl/grdfs_out_if.sv
rtl/grdfs_cfg_if.sv
rtl/grdfs_adj_mem.sv
rtl/grdfs_stack.sv
rtl/graph_reachability_dfs_core.sv
rtl/grdfs_checker.sv
bench/tb_graph_reachability_dfs_core.sv
